[design/keyed_record_table_macros.svh]
// ---------------------------------------------------------------------------
// keyed_record_table assertion macros
// Shared concurrent assertion forms for the keyed record table RTL.
// ---------------------------------------------------------------------------
`ifndef KEYED_RECORD_TABLE_MACROS_SVH
`define KEYED_RECORD_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define KRT_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("keyed_record_table: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define KRT_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("keyed_record_table: next-cycle check failed");

`endif

[design/krt_pkg.sv]
// ---------------------------------------------------------------------------
// krt_pkg
// Types, codes and defaults shared by the keyed record table modules.
// ---------------------------------------------------------------------------
package krt_pkg;

  localparam int KRT_CAPACITY = 64;
  localparam int KEY_W        = 32;
  localparam int VAL_W        = 32;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_FIND   = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_DUP       = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  typedef struct packed {
    mode_t                   mode;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] found_value;
  } out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    load;
    logic    scan;
    logic    shift_init;
    logic    shift;
    logic    append;
    logic    upd_write;
    logic    dec_count;
    logic    finish;
    logic    take_value;
    status_t res_status;
  } ctrl_t;

  // Datapath to controller status.
  typedef struct packed {
    mode_t mode;
    logic  scan_done;
    logic  hit;
    logic  full;
    logic  shift_done;
  } stat_t;

endpackage

[design/krt_ram.sv]
// ---------------------------------------------------------------------------
// krt_ram
// Generic one-write, one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module krt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[design/krt_ctrl.sv]
// ---------------------------------------------------------------------------
// krt_ctrl
// Request sequencer: scan for the key, then shift, append, update or report.
// ---------------------------------------------------------------------------
module krt_ctrl
  import krt_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat_i,
  output ctrl_t cmd_o,
  output logic  busy
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          if (stat_i.mode == MODE_DELETE && stat_i.hit) begin
            state_nxt = S_SHIFT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SHIFT: begin
        if (stat_i.shift_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = STS_OK;
    case (state_r)
      S_IDLE: begin
        cmd_o.load = start;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          case (stat_i.mode)
            MODE_INSERT: begin
              cmd_o.finish = 1'b1;
              if (stat_i.full) begin
                cmd_o.res_status = STS_FULL;
              end else if (stat_i.hit) begin
                cmd_o.res_status = STS_DUP;
              end else begin
                cmd_o.append = 1'b1;
              end
            end
            MODE_DELETE: begin
              if (stat_i.hit) begin
                cmd_o.shift_init = 1'b1;
              end else begin
                cmd_o.finish     = 1'b1;
                cmd_o.res_status = STS_NOT_FOUND;
              end
            end
            MODE_FIND: begin
              cmd_o.finish = 1'b1;
              if (stat_i.hit) begin
                cmd_o.take_value = 1'b1;
              end else begin
                cmd_o.res_status = STS_NOT_FOUND;
              end
            end
            MODE_UPDATE: begin
              cmd_o.finish = 1'b1;
              if (stat_i.hit) begin
                cmd_o.upd_write = 1'b1;
              end else begin
                cmd_o.res_status = STS_NOT_FOUND;
              end
            end
            default: cmd_o.finish = 1'b1;
          endcase
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (stat_i.shift_done) begin
          cmd_o.dec_count = 1'b1;
          cmd_o.finish    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[design/krt_dpath.sv]
// ---------------------------------------------------------------------------
// krt_dpath
// Key and value stores, scan pointer, compare stage and result register.
// ---------------------------------------------------------------------------
`include "keyed_record_table_macros.svh"

module krt_dpath
  import krt_pkg::*;
#(
  parameter int CAPACITY = KRT_CAPACITY
) (
  input  logic  clk,
  input  logic  rst_n,
  input  in_t   in_data,
  input  ctrl_t cmd_i,
  output stat_t stat_o,
  output logic  out_valid,
  output out_t  out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Control registers
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          out_valid_r, out_valid_nxt;
  // Payload registers
  in_t           req_r;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  out_t          out_data_r, out_data_nxt;

  // RAM ports
  logic             key_we, val_we;
  logic [AW-1:0]    waddr;
  logic [KEY_W-1:0] key_wdata, key_rdata;
  logic [VAL_W-1:0] val_wdata, val_rdata;
  logic             issue;
  logic             hit_now;
  logic             shift_wr;

  krt_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (key_rdata)
  );

  krt_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (ptr_r[AW-1:0]),
    .rdata (val_rdata)
  );

  always_comb begin
    issue    = (cmd_i.scan || cmd_i.shift) && (ptr_r < count_r);
    hit_now  = rd_vld_r && (key_rdata == KEY_W'(req_r.key));
    shift_wr = cmd_i.shift && rd_vld_r;

    key_we    = cmd_i.append || shift_wr;
    val_we    = cmd_i.append || cmd_i.upd_write || shift_wr;
    key_wdata = shift_wr ? key_rdata : KEY_W'(req_r.key);
    val_wdata = shift_wr ? val_rdata : req_r.value;
    if (cmd_i.append) begin
      waddr = count_r[AW-1:0];
    end else if (shift_wr) begin
      waddr = rd_idx_r - AW'(1);
    end else begin
      waddr = rd_idx_r;
    end

    stat_o.mode       = req_r.mode;
    stat_o.hit        = hit_now;
    stat_o.scan_done  = hit_now || (ptr_r == count_r && !rd_vld_r);
    stat_o.full       = (count_r == CW'(CAPACITY));
    stat_o.shift_done = (ptr_r == count_r) && !rd_vld_r;
  end

  always_comb begin
    ptr_nxt       = ptr_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    count_nxt     = count_r;
    out_valid_nxt = cmd_i.finish;
    out_data_nxt  = out_data_r;

    if (cmd_i.load) begin
      ptr_nxt = '0;
    end else if (cmd_i.shift_init) begin
      ptr_nxt = CW'(rd_idx_r) + CW'(1);
    end else if (issue) begin
      ptr_nxt    = ptr_r + CW'(1);
      rd_vld_nxt = 1'b1;
      rd_idx_nxt = ptr_r[AW-1:0];
    end

    if (cmd_i.append) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd_i.dec_count) begin
      count_nxt = count_r - CW'(1);
    end

    if (cmd_i.finish) begin
      out_data_nxt.status      = cmd_i.res_status;
      out_data_nxt.found_value = cmd_i.take_value ? val_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ptr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ptr_r       <= ptr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_r <= in_data;
    end
    rd_idx_r   <= rd_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KRT_ASSERT_NOW(a_no_append_full, clk, rst_n, cmd_i.append, count_r < CW'(CAPACITY))
  `KRT_ASSERT_NOW(a_shift_src_live, clk, rst_n, shift_wr, CW'(rd_idx_r) < count_r)

endmodule

[design/keyed_record_table.sv]
// ---------------------------------------------------------------------------
// keyed_record_table
// Fixed-capacity unsorted key/value table with insert, delete, find, update.
// ---------------------------------------------------------------------------
// A request transfers when start is high and busy is low; busy then stays
// high until the result is out. Every request yields exactly one result,
// shown on out_data for a single cycle with out_valid high; the receiver
// cannot stall it, so capture it on that cycle. A request walks the stored
// records in order through the key RAM's single read port, one record per
// cycle; a find, update, failed delete or insert needs only this scan. A
// successful delete then moves every later record down one slot through
// the same read port, one per cycle; the scan stops at the match, so scan
// and move together touch each record once. Reset empties the table at
// once; no clearing pass is needed since only slots below the record count
// are ever read.
// ---------------------------------------------------------------------------
`include "keyed_record_table_macros.svh"

module keyed_record_table
  import krt_pkg::*;
#(
  parameter int CAPACITY = KRT_CAPACITY   // 1 to 1024 records
) (
  input  logic clk,
  input  logic rst_n,
  // Request channel
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  // Result channel
  output logic out_valid,
  output out_t out_data
);

  ctrl_t cmd;
  stat_t stat;

  // Sequencer: decides what each cycle of a request does.
  krt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy)
  );

  // Storage, scan compare and result register.
  krt_dpath #(.CAPACITY(CAPACITY)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // A result only appears as the sequencer drops back to idle.
  `KRT_ASSERT_NOW(a_result_when_idle, clk, rst_n, out_valid, !busy)
  // An accepted request holds off the next one.
  `KRT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

endmodule
